// ===== design/gupc_pkg.sv =====
// Shared types and constants for the GTP-U uplink packet classifier.
// No dependencies; imported by every module of the block.
package gupc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CLASS_W = 3;
    localparam int unsigned CFG_W   = 48;
    localparam int unsigned CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_IP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd2;

    localparam logic [31:0] BCAST_IP_RESET = 32'hFFFF_FFFF;

    // class codes
    localparam logic [CLASS_W-1:0] CLS_GTP_DATA = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_ECHO     = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_UNSUPP   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_HOST     = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_FRAG     = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_BADCSUM  = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_UNKNOWN  = 3'd6;

    // header offsets and field values
    localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
    localparam logic [7:0]  POS_MAC_END  = 8'd6;
    localparam logic [7:0]  POS_ETYPE_HI = 8'd12;
    localparam logic [7:0]  POS_ETYPE_LO = 8'd13;
    localparam logic [7:0]  POS_FRAG_HI  = 8'd20;
    localparam logic [7:0]  POS_FRAG_LO  = 8'd21;
    localparam logic [7:0]  POS_PROTO    = 8'd23;
    localparam logic [7:0]  POS_DIP_LO   = 8'd30;
    localparam logic [7:0]  POS_DIP_HI   = 8'd33;
    localparam logic [7:0]  POS_MAX      = 8'd255;
    localparam logic [3:0]  IHL_MASK     = 4'hF;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] FRAG_DF_ONLY = 16'h4000;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [15:0] GTP_UDP_PORT = 16'd2152;
    localparam logic [7:0]  GTP_T_DATA   = 8'd255;
    localparam logic [7:0]  GTP_T_ECHO   = 8'd1;
    localparam logic [3:0]  MCAST_NIBBLE = 4'hE;

    // field groups reached
    localparam int unsigned REACH_ETH = 0;
    localparam int unsigned REACH_IP  = 1;
    localparam int unsigned REACH_UDP = 2;
    localparam int unsigned REACH_GTP = 3;

    // queue between capture and classification
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // header fields of one finished frame
    typedef struct packed {
        logic        csum_bad;
        logic [47:0] dest_mac;
        logic [15:0] eth_type;
        logic [15:0] frag_field;
        logic [7:0]  protocol;
        logic [31:0] dest_ip;
        logic [15:0] udp_port;
        logic [7:0]  gtp_type;
        logic [3:0]  reached;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== design/gtpu_uplink_packet_classifier_core.sv =====
// Top level of the GTP-U uplink packet classifier: configuration registers,
// capture front end, record queue and classifying back end. Uses gupc_pkg.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_frame_byte, i_frame_first,
//                                                  i_frame_last, i_ip_csum_bad,
//                                                  i_l4_csum_bad
//   output    out        o_out_valid / i_out_stall o_packet_class
//   config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One octet word per cycle is taken while o_in_stall is low; the capture
// logic only counts and loads registers. After the last octet of a frame,
// its record passes through the queue, then the output register. Reset is
// synchronous and active low. Input stalls only while the two-entry record
// queue is full, i.e. when two finished frames wait behind a stalled output.
module gtpu_uplink_packet_classifier_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [gupc_pkg::BYTE_W-1:0]          i_frame_byte,
    input  logic                                 i_frame_first,
    input  logic                                 i_frame_last,
    input  logic                                 i_ip_csum_bad,
    input  logic                                 i_l4_csum_bad,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [gupc_pkg::CLASS_W-1:0]         o_packet_class,
    input  logic                                 i_cfg_we,
    input  logic [gupc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gupc_pkg::CFG_W-1:0]           i_cfg_data
);
    import gupc_pkg::*;

    logic [31:0] r_own_ip, r_bcast_ip;
    logic [47:0] r_own_mac;
    logic        accept, push, pop;
    t_rec        push_rec, head_rec;
    t_qstat      qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip   <= '0;
            r_bcast_ip <= BCAST_IP_RESET;
            r_own_mac  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OWN_IP:   r_own_ip   <= i_cfg_data[31:0];
                CFG_BCAST_IP: r_bcast_ip <= i_cfg_data[31:0];
                CFG_OWN_MAC:  r_own_mac  <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = qstat.full;
    assign accept     = i_in_valid & ~o_in_stall;

    gupc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_frame_byte  (i_frame_byte),
        .i_frame_first (i_frame_first),
        .i_frame_last  (i_frame_last),
        .i_ip_csum_bad (i_ip_csum_bad),
        .i_l4_csum_bad (i_l4_csum_bad),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    gupc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_stat  (qstat)
    );

    gupc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (head_rec),
        .i_qstat        (qstat),
        .i_own_ip       (r_own_ip),
        .i_bcast_ip     (r_bcast_ip),
        .i_own_mac      (r_own_mac),
        .i_out_stall    (i_out_stall),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_packet_class (o_packet_class)
    );

endmodule

// ===== design/gupc_front.sv =====
// Front end: counts frame octets and captures header fields at fixed and
// IHL-derived offsets; pushes one record per frame. Uses gupc_pkg.
module gupc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [gupc_pkg::BYTE_W-1:0]   i_frame_byte,
    input  logic                          i_frame_first,
    input  logic                          i_frame_last,
    input  logic                          i_ip_csum_bad,
    input  logic                          i_l4_csum_bad,
    output logic                          o_push,
    output gupc_pkg::t_rec                o_rec
);
    import gupc_pkg::*;

    logic [7:0] r_pos, n_pos, base_pos;
    logic [3:0] r_hw, n_hw, base_hw;
    t_rec       r_cap, n_cap, base_cap;
    logic [7:0] udp_at;

    always_comb begin
        base_pos = i_frame_first ? 8'd0 : r_pos;
        base_hw  = i_frame_first ? 4'd0 : r_hw;
        base_cap = r_cap;
        if (i_frame_first) begin
            base_cap          = '0;
            base_cap.csum_bad = i_ip_csum_bad | i_l4_csum_bad;
        end

        n_pos  = (base_pos == POS_MAX) ? POS_MAX : base_pos + 8'd1;
        n_hw   = base_hw;
        n_cap  = base_cap;
        udp_at = ETH_HDR_LEN + {2'b00, base_hw, 2'b00};

        if (base_pos < POS_MAC_END)
            n_cap.dest_mac = {base_cap.dest_mac[39:0], i_frame_byte};
        if (base_pos == POS_ETYPE_HI || base_pos == POS_ETYPE_LO)
            n_cap.eth_type = {base_cap.eth_type[7:0], i_frame_byte};
        if (base_pos == POS_ETYPE_LO)
            n_cap.reached[REACH_ETH] = 1'b1;
        if (base_pos == ETH_HDR_LEN)
            n_hw = i_frame_byte[3:0] & IHL_MASK;
        if (base_pos == POS_FRAG_HI || base_pos == POS_FRAG_LO)
            n_cap.frag_field = {base_cap.frag_field[7:0], i_frame_byte};
        if (base_pos == POS_PROTO)
            n_cap.protocol = i_frame_byte;
        if (base_pos >= POS_DIP_LO && base_pos <= POS_DIP_HI)
            n_cap.dest_ip = {base_cap.dest_ip[23:0], i_frame_byte};
        if (base_pos == POS_DIP_HI)
            n_cap.reached[REACH_IP] = 1'b1;
        // UDP/GTP offsets follow the IHL; never before the IHL octet itself
        if (base_pos > ETH_HDR_LEN) begin
            if (base_pos == udp_at + 8'd2 || base_pos == udp_at + 8'd3)
                n_cap.udp_port = {base_cap.udp_port[7:0], i_frame_byte};
            if (base_pos == udp_at + 8'd3)
                n_cap.reached[REACH_UDP] = 1'b1;
            if (base_pos == udp_at + 8'd9) begin
                n_cap.gtp_type           = i_frame_byte;
                n_cap.reached[REACH_GTP] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hw  <= '0;
            r_cap <= '0;
        end else if (i_accept) begin
            if (i_frame_last) begin
                r_pos <= '0;
                r_hw  <= '0;
                r_cap <= '0;
            end else begin
                r_pos <= n_pos;
                r_hw  <= n_hw;
                r_cap <= n_cap;
            end
        end
    end

    assign o_push = i_accept & i_frame_last;
    assign o_rec  = n_cap;

endmodule

// ===== design/gupc_queue.sv =====
// Short record queue between capture and classification.
// Uses gupc_pkg for the record type and depth.
module gupc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gupc_pkg::t_rec  i_rec,
    input  logic            i_pop,
    output gupc_pkg::t_rec  o_rec,
    output gupc_pkg::t_qstat o_stat
);
    import gupc_pkg::*;

    t_rec             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_CW-1:0]  r_cnt;

    function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
        ptr_inc = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= ptr_inc(r_wp);
            if (i_pop)
                r_rp <= ptr_inc(r_rp);
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_rec        = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full && !i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("queue read while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== design/gupc_back.sv =====
// Back end: classifies the record at the queue head against the interface
// addresses and holds the class in the output register. Uses gupc_pkg.
module gupc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gupc_pkg::t_rec                i_rec,
    input  gupc_pkg::t_qstat              i_qstat,
    input  logic [31:0]                   i_own_ip,
    input  logic [31:0]                   i_bcast_ip,
    input  logic [47:0]                   i_own_mac,
    input  logic                          i_out_stall,
    output logic                          o_pop,
    output logic                          o_out_valid,
    output logic [gupc_pkg::CLASS_W-1:0]  o_packet_class
);
    import gupc_pkg::*;

    logic               r_valid;
    logic [CLASS_W-1:0] r_class;
    logic [CLASS_W-1:0] cls;
    logic [7:0]         mac_hi;

    always_comb begin
        mac_hi = i_rec.dest_mac[47:40];
        priority if (i_rec.csum_bad)
            cls = CLS_BADCSUM;
        else if (!i_rec.reached[REACH_ETH])
            cls = CLS_UNKNOWN;
        else if (i_rec.eth_type == ETYPE_IPV4) begin
            priority if (!i_rec.reached[REACH_IP])
                cls = CLS_UNKNOWN;
            else if (i_rec.frag_field != 16'h0000 && i_rec.frag_field != FRAG_DF_ONLY)
                cls = CLS_FRAG;
            else if (i_rec.dest_ip == i_own_ip) begin
                priority if (i_rec.protocol != PROTO_UDP)
                    cls = CLS_HOST;
                else if (!i_rec.reached[REACH_UDP])
                    cls = CLS_UNKNOWN;
                else if (i_rec.udp_port != GTP_UDP_PORT)
                    cls = CLS_HOST;
                else if (!i_rec.reached[REACH_GTP])
                    cls = CLS_UNKNOWN;
                else if (i_rec.gtp_type == GTP_T_DATA)
                    cls = CLS_GTP_DATA;
                else if (i_rec.gtp_type == GTP_T_ECHO)
                    cls = CLS_ECHO;
                else
                    cls = CLS_UNSUPP;
            end
            else if (i_rec.dest_ip[31:28] == MCAST_NIBBLE)
                cls = CLS_HOST;
            else if (i_rec.dest_ip == i_bcast_ip)
                cls = CLS_HOST;
            else
                cls = CLS_UNKNOWN;
        end
        // non-IPv4: ours, group address or universally administered
        else if (i_rec.dest_mac == i_own_mac || mac_hi[0] || !mac_hi[1])
            cls = CLS_HOST;
        else
            cls = CLS_UNKNOWN;
    end

    assign o_pop = !i_qstat.empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop)
            r_class <= cls;
    end

    assign o_out_valid    = r_valid;
    assign o_packet_class = r_class;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> (r_valid && $stable(r_class)))
        else $error("stalled class changed");
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped word not presented");
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_class <= CLS_UNKNOWN))
        else $error("class code out of range");

endmodule
